### hw/rtl/fpcrc_pkg.sv
`timescale 1ns / 1ps
// fpcrc_pkg: types, constants and the crc-16/modbus byte update for the frame parser
// used by frame_parser_crc16_check_core; no dependencies

package fpcrc_pkg;

    // largest payload the block supports, capped by the 7-bit length register
    localparam int unsigned PAYLOAD_CEILING = 64;
    localparam int unsigned LIMIT_CAP   = (PAYLOAD_CEILING > 127) ? 127 : PAYLOAD_CEILING;
    localparam logic [7:0]  LIMIT_CAP_B = LIMIT_CAP[7:0];

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0]  START_BYTE_RST   = 8'hAA;
    localparam logic [6:0]  LENGTH_LIMIT_RST = 7'd64;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_START_BYTE   = 1'b0,
        REG_LENGTH_LIMIT = 1'b1
    } cfg_reg_t;

    // one-hot parse phases
    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_CMD     = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CRC_LO  = 6'b010000,
        PH_CRC_HI  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic        frame_done;
        logic        crc_ok;
        logic [7:0]  command;
        logic [6:0]  length;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic        length_rejected;
    } result_t;

    // reflected crc-16 update, one byte, bit at a time
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hw/rtl/frame_parser_crc16_check_core.sv
`timescale 1ns / 1ps
// frame_parser_crc16_check_core: length-prefixed frame parser with crc-16/modbus check
// depends on fpcrc_pkg
//
// usage:
//   input channel (in_valid / in_ready / rx_byte) carries one received byte per request.
//   output channel (out_valid / out_ready / result fields) carries exactly one result per
//   accepted byte: a payload byte with its index, a frame-done report with both crcs and
//   the verdict, a length-rejected flag, or an all-zero result for framing bytes.
//   frame layout: start byte, command, length, payload (length bytes), crc low, crc high.
//   the crc covers command, length and payload.
//   configuration: cfg_write_en / cfg_index / cfg_data write start_byte (index 0) or
//   length_limit (index 1); write only while the block is idle.
// result timing and throughput:
//   result valid in the cycle after the input request is accepted; one byte per cycle
//   sustained while out_ready stays high. the byte-wise crc update and phase step sit
//   between the parse state and the output register, which sets the cycle time.
// reset: hunting for the start byte, crc at 0xffff, start_byte 0xaa, length_limit 64,
//   output register empty.
// stall: the output register holds its result while out_ready is low; in_ready drops
//   only when that register is full and not being drained, so nothing is lost.

module frame_parser_crc16_check_core
    import fpcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [5:0]  payload_index,
    output logic        frame_done,
    output logic        crc_ok,
    output logic [7:0]  command,
    output logic [6:0]  length,
    output logic [15:0] received_crc,
    output logic [15:0] computed_crc,
    output logic        length_rejected
);

    // configuration registers
    logic [7:0]  start_byte_reg;
    logic [6:0]  length_limit_reg;

    // parse state
    phase_t      phase_reg,      phase_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  command_reg,    command_next;
    logic [6:0]  held_len_reg,   held_len_next;
    logic [6:0]  count_reg,      count_next;
    logic [7:0]  crc_lo_reg,     crc_lo_next;

    // output register
    logic        out_valid_reg;
    result_t     result_reg,     result_next;

    logic        accept;
    logic [15:0] crc_upd;
    logic [7:0]  eff_limit;
    logic [6:0]  count_inc;
    logic [15:0] rx_crc;

    // output register takes a new result whenever it is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign crc_upd   = crc16_byte(crc_reg, rx_byte);
    // effective limit is the smaller of the register and the supported maximum
    assign eff_limit = ({1'b0, length_limit_reg} > LIMIT_CAP_B) ? LIMIT_CAP_B
                                                                : {1'b0, length_limit_reg};
    assign count_inc = count_reg + 7'd1;
    assign rx_crc    = {rx_byte, crc_lo_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        command_next  = command_reg;
        held_len_next = held_len_reg;
        count_next    = count_reg;
        crc_lo_next   = crc_lo_reg;
        result_next   = '0;

        case (phase_reg)
            PH_CMD:
            begin
                command_next = rx_byte;
                crc_next     = crc_upd;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                if (rx_byte > eff_limit)
                begin
                    // oversize length: drop the frame, byte is not a start candidate
                    result_next.length_rejected = 1'b1;
                    phase_next                  = PH_HUNT;
                end
                else
                begin
                    held_len_next = rx_byte[6:0];
                    count_next    = '0;
                    crc_next      = crc_upd;
                    phase_next    = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                result_next.payload_valid = 1'b1;
                result_next.payload_byte  = rx_byte;
                result_next.payload_index = count_reg[5:0];
                crc_next                  = crc_upd;
                count_next                = count_inc;
                if (count_inc >= held_len_reg)
                    phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                crc_lo_next = rx_byte;
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                result_next.frame_done   = 1'b1;
                result_next.crc_ok       = (rx_crc == crc_reg);
                result_next.command      = command_reg;
                result_next.length       = held_len_reg;
                result_next.received_crc = rx_crc;
                result_next.computed_crc = crc_reg;
                phase_next               = PH_HUNT;
            end
            default:
            begin
                // hunting, and any code outside the phase set
                if (rx_byte == start_byte_reg)
                begin
                    crc_next   = CRC_INIT;
                    count_next = '0;
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_START_BYTE:   start_byte_reg   <= cfg_data;
                REG_LENGTH_LIMIT: length_limit_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // parse state advances on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            crc_reg      <= CRC_INIT;
            command_reg  <= '0;
            held_len_reg <= '0;
            count_reg    <= '0;
            crc_lo_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            command_reg  <= command_next;
            held_len_reg <= held_len_next;
            count_reg    <= count_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign payload_valid   = result_reg.payload_valid;
    assign payload_byte    = result_reg.payload_byte;
    assign payload_index   = result_reg.payload_index;
    assign frame_done      = result_reg.frame_done;
    assign crc_ok          = result_reg.crc_ok;
    assign command         = result_reg.command;
    assign length          = result_reg.length;
    assign received_crc    = result_reg.received_crc;
    assign computed_crc    = result_reg.computed_crc;
    assign length_rejected = result_reg.length_rejected;

endmodule

### dv/frame_parser_crc16_check_core_test.sv
`timescale 1ns / 1ps
// frame_parser_crc16_check_core_test: self-checking bench for the frame parser and crc check
// depends on fpcrc_pkg and frame_parser_crc16_check_core; needs no files or arguments

module frame_parser_crc16_check_core_test;
    import fpcrc_pkg::*;

    // clock, reset and block ports; every input starts at a known value
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index    = 1'b0;
    logic [7:0]  cfg_data     = 8'h00;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte      = 8'h00;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic        frame_done;
    logic        crc_ok;
    logic [7:0]  command;
    logic [6:0]  length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        length_rejected;

    // bytes waiting to be offered, and reports the parser still owes us
    logic [7:0]  rx_stream[$];
    result_t     due_reports[$];
    logic [7:0]  body_q[$];

    // parser model state, mirrored from the block after reset
    phase_t      fsm_phase   = PH_HUNT;
    logic [15:0] crc_acc     = CRC_INIT;
    logic [7:0]  cmd_hold    = 8'h00;
    logic [6:0]  len_hold    = 7'd0;
    logic [6:0]  byte_count  = 7'd0;
    logic [7:0]  crc_lo_hold = 8'h00;
    logic [7:0]  start_sel   = START_BYTE_RST;
    logic [6:0]  limit_sel   = LENGTH_LIMIT_RST;

    // handshake pacing
    bit          idle_on        = 1'b1;
    int          send_gap       = 0;
    int          stall_left     = 0;
    int          hold_left      = 0;
    bit          long_hold_done = 1'b0;
    int          results_seen   = 0;
    int          error_count    = 0;
    result_t     want_res;

    frame_parser_crc16_check_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_valid   (payload_valid),
        .payload_byte    (payload_byte),
        .payload_index   (payload_index),
        .frame_done      (frame_done),
        .crc_ok          (crc_ok),
        .command         (command),
        .length          (length),
        .received_crc    (received_crc),
        .computed_crc    (computed_crc),
        .length_rejected (length_rejected)
    );

    always #5 clk = ~clk;

    // crc-16/modbus, one data bit per step: feedback is the lsb xor the data bit
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc_in,
                                                    input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = r[0] ^ data[k];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // the length limit in force: the register value, capped at the supported payload
    function automatic int eff_len_limit();
        return (int'(limit_sel) > int'(LIMIT_CAP)) ? int'(LIMIT_CAP) : int'(limit_sel);
    endfunction

    // advance the parser model by one accepted byte and queue the report it owes
    task automatic parse_rx_byte(input logic [7:0] b);
        result_t     r;
        logic [15:0] rx_crc;
        r = '0;
        case (fsm_phase)
            PH_CMD:
            begin
                cmd_hold  = b;
                crc_acc   = modbus_crc_step(crc_acc, b);
                fsm_phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (int'(b) > eff_len_limit())
                begin
                    // oversize length drops the frame; this byte never opens a new one
                    r.length_rejected = 1'b1;
                    fsm_phase = PH_HUNT;
                end
                else
                begin
                    len_hold   = b[6:0];
                    byte_count = 7'd0;
                    crc_acc    = modbus_crc_step(crc_acc, b);
                    fsm_phase  = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = byte_count[5:0];
                crc_acc    = modbus_crc_step(crc_acc, b);
                byte_count = byte_count + 7'd1;
                if (byte_count >= len_hold)
                    fsm_phase = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                crc_lo_hold = b;
                fsm_phase   = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rx_crc         = {b, crc_lo_hold};
                r.frame_done   = 1'b1;
                r.crc_ok       = (rx_crc == crc_acc);
                r.command      = cmd_hold;
                r.length       = len_hold;
                r.received_crc = rx_crc;
                r.computed_crc = crc_acc;
                fsm_phase      = PH_HUNT;
            end
            default:
            begin
                // hunting: only the start byte moves us on, and it restarts the crc
                if (b == start_sel)
                begin
                    crc_acc    = CRC_INIT;
                    byte_count = 7'd0;
                    fsm_phase  = PH_CMD;
                end
                else
                    fsm_phase = PH_HUNT;
            end
        endcase
        due_reports.push_back(r);
    endtask

    task automatic report_error(input string msg);
        if (error_count < 30)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("report %0d field %s: got %h, expected %h",
                                   results_seen, name, got, want));
    endtask

    // request driver: holds each byte until taken, idles in short random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(1, 9) - 1;
                    in_valid <= 1'b0;
                end
                else if (rx_stream.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_stream.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // report monitor: checks each taken report, and throttles out_ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_reports.size() == 0)
                    report_error($sformatf("report %0d arrived with none pending",
                                           results_seen));
                else
                begin
                    want_res = due_reports.pop_front();
                    compare_field("payload_valid", 16'(payload_valid),
                                  16'(want_res.payload_valid));
                    compare_field("payload_byte", 16'(payload_byte),
                                  16'(want_res.payload_byte));
                    compare_field("payload_index", 16'(payload_index),
                                  16'(want_res.payload_index));
                    compare_field("frame_done", 16'(frame_done),
                                  16'(want_res.frame_done));
                    compare_field("crc_ok", 16'(crc_ok), 16'(want_res.crc_ok));
                    compare_field("command", 16'(command), 16'(want_res.command));
                    compare_field("length", 16'(length), 16'(want_res.length));
                    compare_field("received_crc", received_crc, want_res.received_crc);
                    compare_field("computed_crc", computed_crc, want_res.computed_crc);
                    compare_field("length_rejected", 16'(length_rejected),
                                  16'(want_res.length_rejected));
                end
            end
            // one long hold-off so the output register fills and in_ready drops
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 120)
            begin
                long_hold_done = 1'b1;
                hold_left = 59;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // register write, only while the parser is idle; the model copy follows
    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_START_BYTE)
            start_sel = val;
        else
            limit_sel = val[6:0];
    endtask

    // random payload, with the start byte mixed in as plain data now and then
    task automatic fill_body(input int n);
        for (int i = 0; i < n; i++)
            body_q.push_back(($urandom_range(0, 7) == 0) ? start_sel
                                                         : 8'($urandom_range(0, 255)));
    endtask

    // full frame around body_q, crc low byte first, optionally with a corrupted crc
    task automatic queue_frame(input logic [7:0] cmd_b, input logic [7:0] len_b,
                               input bit bad_crc);
        logic [15:0] c;
        c = CRC_INIT;
        rx_stream.push_back(start_sel);
        rx_stream.push_back(cmd_b);
        c = modbus_crc_step(c, cmd_b);
        rx_stream.push_back(len_b);
        c = modbus_crc_step(c, len_b);
        foreach (body_q[i])
        begin
            rx_stream.push_back(body_q[i]);
            c = modbus_crc_step(c, body_q[i]);
        end
        if (bad_crc)
            c = c ^ 16'($urandom_range(1, 16'hFFFF));
        rx_stream.push_back(c[7:0]);
        rx_stream.push_back(c[15:8]);
        body_q.delete();
    endtask

    task automatic queue_rejected(input logic [7:0] cmd_b, input logic [7:0] len_b);
        rx_stream.push_back(start_sel);
        rx_stream.push_back(cmd_b);
        rx_stream.push_back(len_b);
    endtask

    // mostly good frames of small size, plus oversize lengths, cut-off frames and noise
    task automatic queue_random_traffic(input int n_bytes);
        int queued;
        int pick;
        int lim;
        int len_n;
        int cut;
        queued = 0;
        while (queued < n_bytes)
        begin
            lim  = eff_len_limit();
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    len_n = $urandom_range(0, lim);
                else
                    len_n = $urandom_range(0, (lim < 6) ? lim : 6);
                fill_body(len_n);
                queue_frame(8'($urandom_range(0, 255)), 8'(len_n),
                            $urandom_range(0, 5) == 0);
                queued += len_n + 5;
            end
            else if (pick < 82)
            begin
                queue_rejected(8'($urandom_range(0, 255)), 8'($urandom_range(lim + 1, 255)));
                queued += 3;
            end
            else if (pick < 92)
            begin
                // frame cut short: the bytes that follow get swallowed as its tail
                rx_stream.push_back(start_sel);
                rx_stream.push_back(8'($urandom_range(0, 255)));
                queued += 2;
                if (lim > 0)
                begin
                    len_n = $urandom_range(1, (lim < 8) ? lim : 8);
                    cut   = $urandom_range(0, len_n - 1);
                    rx_stream.push_back(8'(len_n));
                    fill_body(cut);
                    foreach (body_q[i])
                        rx_stream.push_back(body_q[i]);
                    body_q.delete();
                    queued += cut + 1;
                end
            end
            else
            begin
                // line noise while hunting; not counted toward the traffic size
                cut = $urandom_range(1, 4);
                for (int i = 0; i < cut; i++)
                    rx_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // sender pause: nothing queued, nothing in flight, every report back
    task automatic wait_drained();
        while (rx_stream.size() != 0 || in_valid || due_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: hunting noise, zero-length frame, oversize lengths, bad crc
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h55);
        queue_frame(8'h00, 8'h00, 1'b0);
        // one past the limit
        queue_rejected(8'h12, 8'd65);
        // start byte as command and as a rejected length: neither opens a frame
        queue_rejected(8'hAA, 8'hAA);
        queue_rejected(8'h01, 8'hFF);
        // start byte and all-ones inside the payload, wrong crc
        body_q.push_back(8'hAA);
        body_q.push_back(8'hFF);
        queue_frame(8'hFF, 8'h02, 1'b1);
        wait_drained();

        // reset settings, random traffic; the long hold-off lands in here
        queue_random_traffic(130);
        wait_drained();

        // lowest settings: start byte zero, only empty frames pass; no idling here
        write_reg(REG_START_BYTE, 8'h00);
        write_reg(REG_LENGTH_LIMIT, 8'h00);
        @(negedge clk);
        idle_on = 1'b0;
        queue_random_traffic(90);
        wait_drained();

        // highest settings: limit above the cap, so the cap rules; one full-size frame
        write_reg(REG_START_BYTE, 8'hFF);
        write_reg(REG_LENGTH_LIMIT, 8'hFF);
        @(negedge clk);
        idle_on = 1'b1;
        fill_body(int'(LIMIT_CAP));
        queue_frame(8'h5A, LIMIT_CAP_B, 1'b0);
        queue_random_traffic(100);
        wait_drained();

        write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
        write_reg(REG_LENGTH_LIMIT, 8'($urandom_range(1, 20)));
        @(negedge clk);
        queue_random_traffic(100);
        wait_drained();

        // last stretch at full rate on both sides
        write_reg(REG_START_BYTE, START_BYTE_RST);
        write_reg(REG_LENGTH_LIMIT, 8'(LENGTH_LIMIT_RST));
        @(negedge clk);
        idle_on = 1'b0;
        queue_random_traffic(130);
        wait_drained();
        repeat (8) @(posedge clk);

        if (due_reports.size() != 0)
            report_error($sformatf("%0d reports never arrived", due_reports.size()));
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
